// File: hw/rtl/particle_update_step_top_defines.svh
// assertion macros for the particle update pipeline
// used by particle_update_step_top, expects clk and arst_n in scope
`ifndef PARTICLE_UPDATE_STEP_TOP_DEFINES_SVH
`define PARTICLE_UPDATE_STEP_TOP_DEFINES_SVH

// same-cycle implication, silent during reset
`define PUS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, silent during reset
`define PUS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/pus_pkg.sv
// shared constants and helpers for the particle update pipeline
// no dependencies
package pus_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int SAT_W = 72;

	// configuration register indexes
	localparam logic [2:0] REG_WIND_X   = 3'd0;
	localparam logic [2:0] REG_WIND_Y   = 3'd1;
	localparam logic [2:0] REG_GRAVITY  = 3'd2;
	localparam logic [2:0] REG_DRAG     = 3'd3;
	localparam logic [2:0] REG_SIZE_ST  = 3'd4;
	localparam logic [2:0] REG_SIZE_END = 3'd5;
	localparam logic [2:0] REG_GRAD_LO  = 3'd6;
	localparam logic [2:0] REG_GRAD_HI  = 3'd7;

	localparam logic [31:0] SIZE_RESET = 32'd65536;

	// clamp a wide signed value into 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [31:0] r;
		begin
			if (v > $signed(72'sh7FFFFFFF))
				r = 32'sh7FFFFFFF;
			else if (v < -$signed(72'sh80000000))
				r = -32'sh7FFFFFFF - 32'sd1;
			else
				r = v[31:0];
			return r;
		end
	endfunction

	// signed divide by 2^16, rounding toward zero
	function automatic logic signed [32:0] tr16(input logic signed [48:0] p);
		logic signed [48:0] s;
		begin
			s = p + (p[48] ? 49'sd65535 : 49'sd0);
			return s[48:16];
		end
	endfunction

	// exact floor(x / 255) for x up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		begin
			s = 17'(x) + 17'(x >> 8) + 17'd1;
			return s[15:8];
		end
	endfunction

endpackage

// File: hw/rtl/particle_update_step_top.sv
// particle_update_step_top: euler update of one particle word per cycle unless stalled, uses pus_pkg
// accepted words pass the entry register, the divider stages and the post stages; one word per cycle unless stalled
// the 33 restoring-division steps of the force/mass quotient set the depth
// a stall at the result port freezes every stage at once, nothing dropped
// arst_n clears valid bits and resets config registers to their defaults
module particle_update_step_top #(
	parameter int FRAC_BITS = pus_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [15:0]        time_step,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] angle,
	input  logic signed [31:0] spin_rate,
	input  logic signed [31:0] life_left,
	input  logic [30:0]        life_total,
	input  logic [30:0]        particle_mass,
	input  logic [30:0]        start_size,
	input  logic [31:0]        base_rgba,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_angle,
	output logic signed [31:0] new_life_left,
	output logic [31:0]        draw_size,
	output logic [31:0]        draw_rgba,
	output logic               alive
);
	import pus_pkg::*;
	`include "particle_update_step_top_defines.svh"

	localparam int F = FRAC_BITS;
	localparam int NW = 33 + F;            // |force| << F
	localparam int DSTEPS = 33;            // quotient bits 32..0
	localparam int PW = F + 35;            // size lerp product
	localparam int CMW = F + 11;           // colour lerp product
	localparam int NPOST = 7;
	localparam logic [F:0] ONE_T = (F+1)'(1) << F;
	localparam logic signed [64:0] FMASK = (65'sd1 <<< F) - 65'sd1;

	typedef struct packed {
		logic [15:0]        dt;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] spin;
		logic signed [31:0] life;
		logic [31:0]        ang;
		logic [31:0]        base;
		logic [30:0]        bsize;
		logic [30:0]        mass;
		logic [30:0]        ltot;
		logic               live;
		logic [NW-1:0]      nx;
		logic [NW-1:0]      ny;
		logic               sx;
		logic               sy;
		logic               ovx;
		logic               ovy;
		logic [30:0]        rx;
		logic [30:0]        ry;
		logic [32:0]        qx;
		logic [32:0]        qy;
		logic [30:0]        lr;
		logic [F:0]         lq;
		logic               lov;
	} dv_t;

	typedef struct packed {
		logic [15:0]            dt;
		logic signed [31:0]     px;
		logic signed [31:0]     py;
		logic signed [31:0]     vx;
		logic signed [31:0]     vy;
		logic signed [31:0]     spin;
		logic signed [31:0]     life;
		logic [31:0]            ang;
		logic [31:0]            base;
		logic [30:0]            bsize;
		logic                   live;
		logic signed [31:0]     ax;
		logic signed [31:0]     ay;
		logic [F:0]             tq;
		logic [31:0]            k;
		logic signed [48:0]     max;
		logic signed [48:0]     may;
		logic signed [48:0]     mspin;
		logic signed [PW-1:0]   sprod;
		logic [F+2:0]           t3;
		logic [31:0]            lerp;
		logic [1:0]             seg;
		logic [F:0]             u;
		logic signed [64:0]     m2x;
		logic signed [64:0]     m2y;
		logic [63:0]            szp;
		logic [3:0][7:0]        ga;
		logic [3:0][CMW-1:0]    cm;
		logic [31:0]            size;
		logic [3:0][7:0]        g;
		logic [3:0][15:0]       bg;
		logic signed [48:0]     m3x;
		logic signed [48:0]     m3y;
		logic [31:0]            rgba;
	} pp_t;

	// configuration registers
	logic signed [31:0] wind_x_q, wind_y_q, gravity_q;
	logic [31:0]        drag_q, size_st_q, size_end_q;
	logic [63:0]        grad_lo_q, grad_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wind_x_q   <= '0;
			wind_y_q   <= '0;
			gravity_q  <= '0;
			drag_q     <= '0;
			size_st_q  <= SIZE_RESET;
			size_end_q <= SIZE_RESET;
			grad_lo_q  <= '1;
			grad_hi_q  <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIND_X:   wind_x_q   <= cfg_data[31:0];
				REG_WIND_Y:   wind_y_q   <= cfg_data[31:0];
				REG_GRAVITY:  gravity_q  <= cfg_data[31:0];
				REG_DRAG:     drag_q     <= cfg_data[31:0];
				REG_SIZE_ST:  size_st_q  <= cfg_data[31:0];
				REG_SIZE_END: size_end_q <= cfg_data[31:0];
				REG_GRAD_LO:  grad_lo_q  <= cfg_data;
				REG_GRAD_HI:  grad_hi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// gradient stop lookup, stop 0 in the low half of the low register
	function automatic logic [31:0] grad_stop(input logic [1:0] s,
			input logic [63:0] lo, input logic [63:0] hi);
		logic [31:0] r;
		begin
			case (s)
				2'd0:    r = lo[31:0];
				2'd1:    r = lo[63:32];
				2'd2:    r = hi[31:0];
				default: r = hi[63:32];
			endcase
			return r;
		end
	endfunction

	// one global advance: every stage moves unless the output word is stuck
	logic en;
	assign en = !result_valid || result_ready;
	assign item_ready = en;

	// ---------------------------------------------------------------
	// entry: lifetime, forces, divider setup
	// ---------------------------------------------------------------
	logic [15+F:0]      dt_wide;
	logic signed [33:0] life_ext;
	logic signed [31:0] life_sat;
	logic signed [32:0] fx33, fy33;
	logic [32:0]        fx_mag, fy_mag;
	logic [NW-1:0]      nx_in, ny_in;
	logic [30:0]        mass_in, ltot_in;
	dv_t                dv_in;

	always_comb begin
		dt_wide  = (16+F)'(time_step) << F;
		life_ext = 34'(life_left) - $signed(34'(dt_wide >> 16));
		life_sat = sat32(SAT_W'(life_ext));
		fx33     = 33'(wind_x_q);
		fy33     = 33'(wind_y_q) + 33'(gravity_q);
		fx_mag   = fx33[32] ? 33'(-fx33) : fx33;
		fy_mag   = fy33[32] ? 33'(-fy33) : fy33;
		nx_in    = {fx_mag, {F{1'b0}}};
		ny_in    = {fy_mag, {F{1'b0}}};
		// zero mass or lifetime counts as one lsb
		mass_in  = (particle_mass == '0) ? 31'd1 : particle_mass;
		ltot_in  = (life_total == '0) ? 31'd1 : life_total;

		dv_in       = '0;
		dv_in.dt    = time_step;
		dv_in.px    = pos_x;
		dv_in.py    = pos_y;
		dv_in.vx    = vel_x;
		dv_in.vy    = vel_y;
		dv_in.spin  = spin_rate;
		dv_in.life  = life_sat;
		dv_in.ang   = angle;
		dv_in.base  = base_rgba;
		dv_in.bsize = start_size;
		dv_in.mass  = mass_in;
		dv_in.ltot  = ltot_in;
		dv_in.live  = !life_sat[31] && (life_sat != '0);
		dv_in.nx    = nx_in;
		dv_in.ny    = ny_in;
		dv_in.sx    = fx33[32];
		dv_in.sy    = fy33[32];
		// quotient of 2^33 or more saturates anyway
		dv_in.ovx   = 32'(nx_in[NW-1:33]) >= 32'(mass_in);
		dv_in.ovy   = 32'(ny_in[NW-1:33]) >= 32'(mass_in);
		dv_in.rx    = 31'(nx_in[NW-1:33]);
		dv_in.ry    = 31'(ny_in[NW-1:33]);
		// age quotient needs bits F..0 only; life >> 1 is the head remainder
		dv_in.lov   = 32'(life_sat[30:1]) >= 32'(ltot_in);
		dv_in.lr    = 31'(life_sat[30:1]);
	end

	// ---------------------------------------------------------------
	// restoring dividers: force/mass and life/life_total, one bit a stage
	// ---------------------------------------------------------------
	dv_t  dv_s [0:DSTEPS];
	logic dv_v [0:DSTEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v[0] <= 1'b0;
		else if (en)
			dv_v[0] <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			dv_s[0] <= dv_in;
	end

	for (genvar k = 0; k < DSTEPS; k++) begin : g_div
		localparam int J = DSTEPS - 1 - k;
		logic [31:0] tx, ty;
		dv_t         nxt;

		always_comb begin
			nxt = dv_s[k];
			tx  = {dv_s[k].rx, dv_s[k].nx[J]};
			ty  = {dv_s[k].ry, dv_s[k].ny[J]};
			if (tx >= {1'b0, dv_s[k].mass}) begin
				nxt.rx    = 31'(tx - {1'b0, dv_s[k].mass});
				nxt.qx[J] = 1'b1;
			end else begin
				nxt.rx = tx[30:0];
			end
			if (ty >= {1'b0, dv_s[k].mass}) begin
				nxt.ry    = 31'(ty - {1'b0, dv_s[k].mass});
				nxt.qy[J] = 1'b1;
			end else begin
				nxt.ry = ty[30:0];
			end
		end

		if (J <= F) begin : g_age
			logic [31:0] tl;
			dv_t         nxt2;
			always_comb begin
				nxt2 = nxt;
				tl   = {dv_s[k].lr, (J == F) ? dv_s[k].life[0] : 1'b0};
				if (tl >= {1'b0, dv_s[k].ltot}) begin
					nxt2.lr    = 31'(tl - {1'b0, dv_s[k].ltot});
					nxt2.lq[J] = 1'b1;
				end else begin
					nxt2.lr = tl[30:0];
				end
			end
			always_ff @(posedge clk) begin
				if (en)
					dv_s[k+1] <= nxt2;
			end
		end else begin : g_noage
			always_ff @(posedge clk) begin
				if (en)
					dv_s[k+1] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v[k+1] <= 1'b0;
			else if (en)
				dv_v[k+1] <= dv_v[k];
		end
	end

	// ---------------------------------------------------------------
	// post stages 1..7
	// ---------------------------------------------------------------
	pp_t  pp_s [1:NPOST];
	pp_t  pp_n [1:NPOST];
	logic pp_v [1:NPOST];

	// stage 1: saturate quotients, age t, drag factor
	dv_t         dq;
	logic [47:0] kp;
	always_comb begin
		dq = dv_s[DSTEPS];
		kp = 48'(drag_q) * 48'(dq.dt);
		pp_n[1]       = '0;
		pp_n[1].dt    = dq.dt;
		pp_n[1].px    = dq.px;
		pp_n[1].py    = dq.py;
		pp_n[1].vx    = dq.vx;
		pp_n[1].vy    = dq.vy;
		pp_n[1].spin  = dq.spin;
		pp_n[1].life  = dq.life;
		pp_n[1].ang   = dq.ang;
		pp_n[1].base  = dq.base;
		pp_n[1].bsize = dq.bsize;
		pp_n[1].live  = dq.live;
		if (dq.sx)
			pp_n[1].ax = (dq.ovx || dq.qx > 33'h080000000) ? 32'sh80000000
				: 32'(-dq.qx);
		else
			pp_n[1].ax = (dq.ovx || dq.qx >= 33'h080000000) ? 32'sh7FFFFFFF
				: 32'(dq.qx);
		if (dq.sy)
			pp_n[1].ay = (dq.ovy || dq.qy > 33'h080000000) ? 32'sh80000000
				: 32'(-dq.qy);
		else
			pp_n[1].ay = (dq.ovy || dq.qy >= 33'h080000000) ? 32'sh7FFFFFFF
				: 32'(dq.qy);
		// t = 1 - life/total, clamped at zero
		pp_n[1].tq = (dq.lov || dq.lq > ONE_T) ? '0 : ONE_T - dq.lq;
		pp_n[1].k  = kp[47:16];
	end

	// stage 2: accel*dt, spin*dt, size lerp product, 3t
	logic signed [32:0] ds;
	always_comb begin
		pp_n[2]       = pp_s[1];
		ds            = $signed(33'(size_end_q)) - $signed(33'(size_st_q));
		pp_n[2].max   = 49'(pp_s[1].ax) * $signed(49'(pp_s[1].dt));
		pp_n[2].may   = 49'(pp_s[1].ay) * $signed(49'(pp_s[1].dt));
		pp_n[2].mspin = 49'(pp_s[1].spin) * $signed(49'(pp_s[1].dt));
		pp_n[2].sprod = PW'(ds) * $signed(PW'(pp_s[1].tq));
		pp_n[2].t3    = (F+3)'(pp_s[1].tq) + (F+3)'({pp_s[1].tq, 1'b0});
	end

	// stage 3: velocity += accel*dt, angle step, size lerp, gradient segment
	logic signed [PW-1:0] lsum;
	logic [2:0]           seg_raw;
	logic [1:0]           seg_c;
	logic [F+2:0]         u_full;
	always_comb begin
		pp_n[3] = pp_s[2];
		if (pp_s[2].live) begin
			pp_n[3].vx  = sat32(SAT_W'(pp_s[2].vx) + SAT_W'(tr16(pp_s[2].max)));
			pp_n[3].vy  = sat32(SAT_W'(pp_s[2].vy) + SAT_W'(tr16(pp_s[2].may)));
			pp_n[3].ang = pp_s[2].ang + 32'(tr16(pp_s[2].mspin));
		end
		lsum         = $signed(PW'(size_st_q) << F) + pp_s[2].sprod;
		pp_n[3].lerp = lsum[F+31:F];
		seg_raw      = pp_s[2].t3[F+2:F];
		seg_c        = (seg_raw > 3'd2) ? 2'd2 : seg_raw[1:0];
		u_full       = pp_s[2].t3 - {1'b0, seg_c, {F{1'b0}}};
		pp_n[3].seg  = seg_c;
		pp_n[3].u    = u_full[F:0];
	end

	// stage 4: drag product, size product, gradient channel products
	logic [31:0]       stop_a, stop_b;
	logic signed [8:0] gdiff [4];
	always_comb begin
		pp_n[4]     = pp_s[3];
		pp_n[4].m2x = 65'(pp_s[3].vx) * $signed(65'(pp_s[3].k));
		pp_n[4].m2y = 65'(pp_s[3].vy) * $signed(65'(pp_s[3].k));
		pp_n[4].szp = 64'(pp_s[3].bsize) * 64'(pp_s[3].lerp);
		stop_a = grad_stop(pp_s[3].seg, grad_lo_q, grad_hi_q);
		stop_b = grad_stop(pp_s[3].seg + 2'd1, grad_lo_q, grad_hi_q);
		for (int c = 0; c < 4; c++) begin
			gdiff[c] = $signed({1'b0, stop_b[8*c +: 8]}) - $signed({1'b0, stop_a[8*c +: 8]});
			pp_n[4].ga[c] = stop_a[8*c +: 8];
			pp_n[4].cm[c] = CMW'(CMW'(gdiff[c]) * $signed(CMW'(pp_s[3].u)));
		end
	end

	// stage 5: velocity -= v*k, size saturate, gradient channels
	logic signed [64:0]    dsum_x, dsum_y;
	logic signed [64:0]    dsh_x, dsh_y;
	logic [63:0]           szs;
	logic signed [CMW-1:0] gsum [4];
	always_comb begin
		pp_n[5] = pp_s[4];
		dsum_x  = pp_s[4].m2x + (pp_s[4].m2x[64] ? FMASK : 65'sd0);
		dsum_y  = pp_s[4].m2y + (pp_s[4].m2y[64] ? FMASK : 65'sd0);
		dsh_x   = dsum_x >>> F;
		dsh_y   = dsum_y >>> F;
		if (pp_s[4].live) begin
			pp_n[5].vx = sat32(SAT_W'(pp_s[4].vx) - SAT_W'(dsh_x));
			pp_n[5].vy = sat32(SAT_W'(pp_s[4].vy) - SAT_W'(dsh_y));
		end
		szs = pp_s[4].szp >> F;
		pp_n[5].size = (szs[63:32] != '0) ? 32'hFFFFFFFF : szs[31:0];
		for (int c = 0; c < 4; c++) begin
			gsum[c] = $signed(CMW'(pp_s[4].ga[c]) << F) + $signed(pp_s[4].cm[c]);
			pp_n[5].g[c] = gsum[c][F+7:F];
		end
	end

	// stage 6: velocity*dt, base times gradient
	always_comb begin
		pp_n[6]     = pp_s[5];
		pp_n[6].m3x = 49'(pp_s[5].vx) * $signed(49'(pp_s[5].dt));
		pp_n[6].m3y = 49'(pp_s[5].vy) * $signed(49'(pp_s[5].dt));
		for (int c = 0; c < 4; c++)
			pp_n[6].bg[c] = 16'(pp_s[5].base[8*c +: 8]) * 16'(pp_s[5].g[c]);
	end

	// stage 7: position step, colour /255, dead particles pass through
	always_comb begin
		pp_n[7] = pp_s[6];
		for (int c = 0; c < 4; c++)
			pp_n[7].rgba[8*c +: 8] = div255(pp_s[6].bg[c]);
		if (pp_s[6].live) begin
			pp_n[7].px = sat32(SAT_W'(pp_s[6].px) + SAT_W'(tr16(pp_s[6].m3x)));
			pp_n[7].py = sat32(SAT_W'(pp_s[6].py) + SAT_W'(tr16(pp_s[6].m3y)));
		end else begin
			pp_n[7].size = 32'(pp_s[6].bsize);
			pp_n[7].rgba = pp_s[6].base;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 1; i <= NPOST; i++)
				pp_s[i] <= pp_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NPOST; i++)
				pp_v[i] <= 1'b0;
		end else if (en) begin
			pp_v[1] <= dv_v[DSTEPS];
			for (int i = 2; i <= NPOST; i++)
				pp_v[i] <= pp_v[i-1];
		end
	end

	// result word comes straight from the last stage register
	assign result_valid  = pp_v[NPOST];
	assign new_pos_x     = pp_s[NPOST].px;
	assign new_pos_y     = pp_s[NPOST].py;
	assign new_vel_x     = pp_s[NPOST].vx;
	assign new_vel_y     = pp_s[NPOST].vy;
	assign new_angle     = pp_s[NPOST].ang;
	assign new_life_left = pp_s[NPOST].life;
	assign draw_size     = pp_s[NPOST].size;
	assign draw_rgba     = pp_s[NPOST].rgba;
	assign alive         = pp_s[NPOST].live;

	// checks
	`PUS_ASSERT_NEXT(a_accept_enters, item_valid && item_ready, dv_v[0],
		"accepted word missing from entry stage")
	`PUS_ASSERT_NEXT(a_stall_freezes, result_valid && !result_ready,
		$stable(dv_v[DSTEPS]) && $stable(pp_v[1]) && $stable(pp_s[1].tq),
		"pipeline moved during output stall")
	`PUS_ASSERT_NOW(a_age_range, pp_v[1] && pp_s[1].live, pp_s[1].tq <= ONE_T,
		"age fraction above one")
	`PUS_ASSERT_NOW(a_alive_life, result_valid && alive, new_life_left > 32'sd0,
		"live particle with non-positive lifetime")

endmodule

// File: tb/sv/tb_particle_update_step_top.sv
// testbench for particle_update_step_top: directed and random particle words
// checked against a scoreboard with its own fixed-point predictor; uses pus_pkg
`timescale 1ns / 1ps

import pus_pkg::*;

// one particle record as it enters the block
typedef struct {
	logic [15:0]        time_step;
	logic signed [31:0] pos_x, pos_y, vel_x, vel_y, angle, spin_rate, life_left;
	logic [30:0]        life_total, particle_mass, start_size;
	logic [31:0]        base_rgba;
} particle_t;

// one updated record as it leaves the block
typedef struct {
	logic [31:0] pos_x, pos_y, vel_x, vel_y, angle, life_left, size, rgba;
	logic        alive;
} update_t;

class particle_scoreboard;
	localparam longint ONE = longint'(1) << FRAC_BITS_DEF;

	logic signed [31:0] wind_x, wind_y, gravity;
	logic [31:0]        drag, size_start, size_end;
	logic [63:0]        stops_lo, stops_hi;
	update_t            pending[$];
	int                 errors, words, dead;

	function new();
		wind_x = 0; wind_y = 0; gravity = 0; drag = 0;
		size_start = SIZE_RESET; size_end = SIZE_RESET;
		stops_lo = '1; stops_hi = '1;
		errors = 0; words = 0; dead = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [63:0] data);
		case (idx)
			REG_WIND_X: wind_x = data[31:0];
			REG_WIND_Y: wind_y = data[31:0];
			REG_GRAVITY: gravity = data[31:0];
			REG_DRAG: drag = data[31:0];
			REG_SIZE_ST: size_start = data[31:0];
			REG_SIZE_END: size_end = data[31:0];
			REG_GRAD_LO: stops_lo = data;
			REG_GRAD_HI: stops_hi = data;
			default: ;
		endcase
	endfunction

	function longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// lerp with truncation toward zero
	function longint blend(longint a, longint b, longint u);
		return (a * ONE + (b - a) * u) / ONE;
	endfunction

	function logic [31:0] stop_color(int k);
		logic [63:0] r;
		r = (k & 2) ? stops_hi : stops_lo;
		return (k & 1) ? r[63:32] : r[31:0];
	endfunction

	function update_t advance(particle_t p);
		update_t     r;
		longint      dt, dtq, px, py, vx, vy, life, ltot, mass, fx, fy, ax, ay, k;
		longint      t, t3, u, lerp, sz, seg, ga, gb, g, b;
		logic [31:0] ca, cb, ang;
		dt = p.time_step;
		dtq = (dt << FRAC_BITS_DEF) >>> 16;
		px = p.pos_x; py = p.pos_y; vx = p.vel_x; vy = p.vel_y;
		ang = p.angle;
		life = clamp32(longint'(p.life_left) - dtq);
		ltot = p.life_total; mass = p.particle_mass;
		r.size = p.start_size;
		r.rgba = p.base_rgba;
		r.alive = life > 0;
		if (r.alive) begin
			if (mass == 0) mass = 1;
			if (ltot == 0) ltot = 1;
			fx = wind_x;
			fy = longint'(wind_y) + longint'(gravity);
			ax = clamp32(fx * ONE / mass);
			ay = clamp32(fy * ONE / mass);
			vx = clamp32(vx + ax * dt / 65536);
			vy = clamp32(vy + ay * dt / 65536);
			k = (longint'(drag) * dt) >>> 16;
			vx = clamp32(vx - vx * k / ONE);
			vy = clamp32(vy - vy * k / ONE);
			px = clamp32(px + vx * dt / 65536);
			py = clamp32(py + vy * dt / 65536);
			ang = ang + 32'(longint'(p.spin_rate) * dt / 65536);
			// age along the lifetime, clamped to [0, 1]
			t = ONE - life * ONE / ltot;
			if (t < 0) t = 0;
			if (t > ONE) t = ONE;
			lerp = blend(longint'(size_start), longint'(size_end), t);
			sz = longint'(p.start_size) * lerp / ONE;
			r.size = (sz > 64'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sz[31:0];
			t3 = 3 * t;
			seg = t3 / ONE;
			if (seg > 2) seg = 2;
			u = t3 - seg * ONE;
			ca = stop_color(int'(seg));
			cb = stop_color(int'(seg) + 1);
			for (int c = 0; c < 4; c++) begin
				ga = ca[8*c +: 8];
				gb = cb[8*c +: 8];
				g = blend(ga, gb, u) & 255;
				b = p.base_rgba[8*c +: 8];
				r.rgba[8*c +: 8] = 8'((b * g) / 255);
			end
		end
		r.pos_x = px[31:0]; r.pos_y = py[31:0];
		r.vel_x = vx[31:0]; r.vel_y = vy[31:0];
		r.angle = ang; r.life_left = life[31:0];
		return r;
	endfunction

	function void note_item(particle_t p);
		update_t e;
		e = advance(p);
		pending.push_back(e);
		words++;
		if (!e.alive) dead++;
	endfunction

	function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	function void check_result(update_t a);
		update_t e;
		if (pending.size() == 0) begin
			$error("result word with nothing expected");
			errors++;
			return;
		end
		e = pending.pop_front();
		cmp("new_pos_x", e.pos_x, a.pos_x);
		cmp("new_pos_y", e.pos_y, a.pos_y);
		cmp("new_vel_x", e.vel_x, a.vel_x);
		cmp("new_vel_y", e.vel_y, a.vel_y);
		cmp("new_angle", e.angle, a.angle);
		cmp("new_life_left", e.life_left, a.life_left);
		cmp("draw_size", e.size, a.size);
		cmp("draw_rgba", e.rgba, a.rgba);
		cmp("alive", 32'(e.alive), 32'(a.alive));
	endfunction
endclass

module tb_particle_update_step_top;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE = 60;   // margin beyond the pipeline depth

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        item_valid = 0;
	logic        item_ready;
	logic        result_valid;
	logic        result_ready = 0;
	particle_t   cur = '{default: '0};
	update_t     got;

	int send_idle = 0;   // percent of cycles the sender holds back
	int recv_stall = 0;  // percent of cycles the receiver stalls
	int idle_cycles = 0;
	int settings = 0;

	particle_scoreboard sb = new();

	always #5 clk = ~clk;

	particle_update_step_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_ready(item_ready),
		.time_step(cur.time_step), .pos_x(cur.pos_x), .pos_y(cur.pos_y),
		.vel_x(cur.vel_x), .vel_y(cur.vel_y), .angle(cur.angle),
		.spin_rate(cur.spin_rate), .life_left(cur.life_left),
		.life_total(cur.life_total), .particle_mass(cur.particle_mass),
		.start_size(cur.start_size), .base_rgba(cur.base_rgba),
		.result_valid(result_valid), .result_ready(result_ready),
		.new_pos_x(got.pos_x), .new_pos_y(got.pos_y),
		.new_vel_x(got.vel_x), .new_vel_y(got.vel_y),
		.new_angle(got.angle), .new_life_left(got.life_left),
		.draw_size(got.size), .draw_rgba(got.rgba), .alive(got.alive)
	);

	// receiver: random stalls, changed on the falling edge
	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall);
	end

	// monitor: both handshakes sampled at the rising edge, plus the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				sb.note_item(cur);
			if (result_valid && result_ready)
				sb.check_result(got);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// config write, only called while the pipeline is empty
	task automatic write_reg(logic [2:0] idx, logic [63:0] data);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic load_config(logic [31:0] wx, logic [31:0] wy, logic [31:0] gr,
			logic [31:0] dr, logic [31:0] ss, logic [31:0] se,
			logic [63:0] glo, logic [63:0] ghi);
		write_reg(REG_WIND_X, {32'h0, wx});
		write_reg(REG_WIND_Y, {32'h0, wy});
		write_reg(REG_GRAVITY, {32'h0, gr});
		write_reg(REG_DRAG, {32'h0, dr});
		write_reg(REG_SIZE_ST, {32'h0, ss});
		write_reg(REG_SIZE_END, {32'h0, se});
		write_reg(REG_GRAD_LO, glo);
		write_reg(REG_GRAD_HI, ghi);
		settings++;
	endtask

	// hold the next word until every expected result is back
	task automatic drain();
		@(negedge clk);
		item_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// offer one word and wait for it to be taken
	task automatic send(particle_t p);
		@(negedge clk);
		if ($urandom_range(99) < send_idle) begin
			item_valid <= 0;
			do @(negedge clk); while ($urandom_range(99) < send_idle);
		end
		item_valid <= 1;
		cur <= p;
		do @(posedge clk); while (!item_ready);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] rand_floor(logic [30:0] lo);
		logic [30:0] v;
		v = ($urandom_range(2) == 0) ? 31'($urandom) : 31'($urandom_range(32'h0020_0000));
		return (v < lo) ? lo : v;
	endfunction

	function automatic particle_t rand_particle();
		particle_t p;
		p.time_step = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
		p.pos_x = rand_word(); p.pos_y = rand_word();
		p.vel_x = rand_word(); p.vel_y = rand_word();
		p.angle = $urandom; p.spin_rate = rand_word();
		p.life_total = rand_floor(31'd3277);
		p.particle_mass = rand_floor(31'd655);
		p.start_size = rand_floor(31'd6554);
		p.base_rgba = $urandom;
		// mostly live particles spread over the whole lifetime
		case ($urandom_range(9))
			0: p.life_left = $urandom_range(p.time_step);                    // dies now
			1: p.life_left = $urandom;                                     // anything
			2: p.life_left = 32'(p.life_total) + $urandom_range(32'hFFFF) + p.time_step;
			default: p.life_left = $urandom_range(p.life_total) + p.time_step + 1;
		endcase
		return p;
	endfunction

	task automatic run_random(int n);
		repeat (n) send(rand_particle());
	endtask

	task automatic run_directed();
		particle_t p;
		p = '{time_step: 16'h1000, pos_x: 32'h0001_0000, pos_y: -32'sh0001_0000,
			vel_x: 32'h0002_0000, vel_y: 32'h0, angle: 32'h0, spin_rate: 32'h0003_0000,
			life_left: 32'h0002_0000, life_total: 31'h0004_0000,
			particle_mass: 31'h0001_0000, start_size: 31'h0001_0000,
			base_rgba: 32'hFFFF_FFFF};
		send(p);
		// zero and full time step
		p.time_step = 16'h0; send(p);
		p.time_step = 16'hFFFF; send(p);
		// lifetime hits exactly zero, then one lsb left
		p.life_left = 32'(p.time_step); send(p);
		p.life_left = 32'(p.time_step) + 1; send(p);
		// lifetime underflow saturates at the most negative value
		p.life_left = 32'h8000_0000; send(p);
		// lifetime above the total clamps the age to zero
		p.life_left = 32'h7FFF_FFFF; send(p);
		p.life_left = 32'(p.life_total) + p.time_step; send(p);
		// extreme positions, velocities, spin
		p.life_left = 32'h0001_0000;
		p.pos_x = 32'h7FFF_FFFF; p.pos_y = 32'h8000_0000;
		p.vel_x = 32'h7FFF_FFFF; p.vel_y = 32'h8000_0000;
		p.spin_rate = 32'h7FFF_FFFF; p.angle = 32'h7FFF_FFFF; send(p);
		p.spin_rate = 32'h8000_0000; p.angle = 32'h8000_0000; send(p);
		// smallest and largest mass, total, size
		p.particle_mass = 31'd655; p.life_total = 31'd3277; p.life_left = 32'd3300;
		p.start_size = 31'd6554; p.base_rgba = 32'h0; send(p);
		p.particle_mass = '1; p.life_total = '1; p.life_left = 32'h7FFF_FFFF;
		p.start_size = '1; p.base_rgba = 32'h80FF_7F01; send(p);
		p.life_left = 32'h0000_1001; send(p);
	endtask

	int n_random;

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// phase one: sender idles 26%, receiver 62%
		send_idle = 26; recv_stall = 62;
		run_directed();
		drain();
		load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h0, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
		run_directed();
		drain();
		load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
			32'h0, 32'hFFFF_FFFF, 64'h0, 64'h0);
		run_directed();
		run_random(200);
		drain();

		// phase two: the other way round
		send_idle = 62; recv_stall = 26;
		for (int s = 0; s < 3; s++) begin
			load_config($urandom_range(32'h0008_0000) - 32'h0004_0000,
				$urandom_range(32'h0008_0000) - 32'h0004_0000, rand_word(),
				$urandom_range(32'h0004_0000), $urandom, $urandom,
				{$urandom, $urandom}, {$urandom, $urandom});
			run_random(150);
			drain();
		end

		// phase three: full rate, random settings including extremes
		send_idle = 0; recv_stall = 0;
		for (int s = 0; s < 4; s++) begin
			load_config(rand_word(), rand_word(), rand_word(), $urandom,
				$urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
			n_random = 200;
			run_random(n_random);
			drain();
		end

		$display("checked %0d particle words (%0d died) over %0d register settings",
			sb.words, sb.dead, settings);
		$display("three handshake pressure phases, directed extremes and random records");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
